>>> rtl/oas_pkg.sv
// Shared types and constants of the overlap-add synthesis block.
// No dependencies; every other file of the block but oas_ram imports this package.
package oas_pkg;

    // Frame geometry.
    localparam int FRAME_SIZE = 1024;
    localparam int POS_W      = $clog2(FRAME_SIZE);
    localparam int HOP_W      = $clog2(FRAME_SIZE + 1);

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 16;
    localparam int CIDX_W    = 10;
    localparam int HOP_CFG_W = 11;
    localparam int SCALE_W   = 32;
    localparam int OUT_W     = 16;
    localparam int ACC_W     = 32;

    // Stream packing.
    localparam int TDATA_IN_W  = 56;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 16;

    // Datapath arithmetic.
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
    localparam int RND_SHIFT  = 15;
    localparam int RND_BIAS   = 16384;
    localparam int RND_W      = PROD_W - RND_SHIFT;
    localparam int MPROD_W    = ACC_W + SCALE_W;
    localparam int OUT_SHIFT  = 36;
    localparam int Q_W        = MPROD_W - OUT_SHIFT;
    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAG = 32768;

    // Configuration.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 1'd1;
    localparam logic [HOP_CFG_W-1:0] HOP_RESET        = 11'd256;
    localparam logic [SCALE_W-1:0]   SCALE_RESET      = 32'd1430967;

    // Commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // One classified request handed from front to back.
    typedef struct packed {
        logic                       is_load;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COEF_W-1:0]          coef;
        logic [POS_W-1:0]           addr;   // frame position, or table index for a load
        logic [POS_W-1:0]           slot;   // ring slot of the sample
        logic                       emit;
        logic                       last;
    } oas_job_t;

endpackage

>>> rtl/oas_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/oas_queue.sv
// Short request queue between the front and back parts of the block.
// Depends on oas_pkg for the request type and queue depth.
module oas_queue
    import oas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  oas_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output oas_job_t head
);

    oas_job_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");
`endif

endmodule

>>> rtl/oas_front.sv
// Front part: accepts stream requests, tracks frame position and ring base,
// and classifies each request into a queue entry. Depends on oas_pkg.
module oas_front
    import oas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic [TUSER_IN_W-1:0]  s_tuser,
    input  logic [HOP_CFG_W-1:0]   hop_size,
    input  logic                   clear_done,
    input  logic                   queue_full,
    output logic                   push,
    output oas_job_t               push_job
);

    logic [POS_W-1:0] frame_position_reg, frame_position_next;
    logic [POS_W-1:0] ring_base_reg, ring_base_next;

    logic                       command;
    logic                       final_frame;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [COEF_W-1:0]          coef_value;
    logic [CIDX_W-1:0]          coef_index;

    logic              accept;
    logic [HOP_W-1:0]  hop_eff;
    logic [POS_W:0]    slot_sum;
    logic [POS_W-1:0]  slot;
    logic [HOP_W:0]    base_sum;
    logic              last_pos;
    logic              index_ok;

    assign command      = s_tuser[0];
    assign final_frame  = s_tuser[1];
    assign sample_value = $signed(s_tdata[SAMPLE_W-1:0]);
    assign coef_value   = s_tdata[SAMPLE_W+COEF_W-1:SAMPLE_W];
    assign coef_index   = s_tdata[SAMPLE_W+COEF_W+CIDX_W-1:SAMPLE_W+COEF_W];

    assign s_tready = clear_done && !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // Hop of zero means a quarter frame; oversize hops clamp to the frame.
        if (hop_size == '0)
        begin
            hop_eff = HOP_W'(FRAME_SIZE / 4);
        end
        else if (int'(hop_size) > FRAME_SIZE)
        begin
            hop_eff = HOP_W'(FRAME_SIZE);
        end
        else
        begin
            hop_eff = HOP_W'(hop_size);
        end

        slot_sum = (POS_W+1)'(ring_base_reg) + (POS_W+1)'(frame_position_reg);
        if (slot_sum >= (POS_W+1)'(FRAME_SIZE))
        begin
            slot_sum = slot_sum - (POS_W+1)'(FRAME_SIZE);
        end
        slot = slot_sum[POS_W-1:0];

        base_sum = (HOP_W+1)'(ring_base_reg) + (HOP_W+1)'(hop_eff);
        if (base_sum >= (HOP_W+1)'(FRAME_SIZE))
        begin
            base_sum = base_sum - (HOP_W+1)'(FRAME_SIZE);
        end

        last_pos = (frame_position_reg == POS_W'(FRAME_SIZE - 1));
        index_ok = (int'(coef_index) < FRAME_SIZE);

        push_job.is_load = (command == CMD_LOAD);
        push_job.sample  = sample_value;
        push_job.coef    = coef_value;
        push_job.addr    = (command == CMD_LOAD) ? POS_W'(coef_index) : frame_position_reg;
        push_job.slot    = slot;
        push_job.emit    = (HOP_W'(frame_position_reg) < hop_eff) || final_frame;
        push_job.last    = final_frame && last_pos;

        // Drop loads that fall outside the table.
        push = accept && ((command == CMD_SAMPLE) || index_ok);

        frame_position_next = frame_position_reg;
        ring_base_next      = ring_base_reg;
        if (accept && (command == CMD_SAMPLE))
        begin
            if (last_pos)
            begin
                frame_position_next = '0;
                ring_base_next      = final_frame ? '0 : POS_W'(base_sum);
            end
            else
            begin
                frame_position_next = frame_position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_position_reg <= '0;
            ring_base_reg      <= '0;
        end
        else
        begin
            frame_position_reg <= frame_position_next;
            ring_base_reg      <= ring_base_next;
        end
    end

`ifndef SYNTHESIS
    a_ring_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(ring_base_reg) < FRAME_SIZE) && (int'(frame_position_reg) < FRAME_SIZE))
        else $error("ring base or frame position out of range");
`endif

endmodule

>>> rtl/oas_back.sv
// Back part: clears the accumulator ring after reset, then carries out queued
// requests (window loads, weighted accumulate, scale and saturate, emit).
// Depends on oas_pkg and oas_ram.
module oas_back
    import oas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  oas_job_t               head,
    input  logic                   queue_empty,
    output logic                   pop,
    input  logic [SCALE_W-1:0]     output_scale,
    output logic                   clear_done,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] clear_cnt_reg, clear_cnt_next;

    oas_job_t                  job_reg, job_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   sum_reg, sum_next;
    logic [MPROD_W-1:0]        mprod_reg, mprod_next;
    logic                      neg_reg, neg_next;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_sample_reg, out_sample_next;
    logic                      out_last_reg, out_last_next;

    logic                      win_we, win_re;
    logic [COEF_W-1:0]         win_rdata;
    logic                      acc_we, acc_re;
    logic [POS_W-1:0]          acc_waddr;
    logic [ACC_W-1:0]          acc_wdata;
    logic [ACC_W-1:0]          acc_rdata;

    logic signed [PROD_W-1:0]  rnd_t;
    logic signed [RND_W-1:0]   rnd;
    logic signed [ACC_W:0]     sum_wide;
    logic [ACC_W-1:0]          mag;
    logic [Q_W-1:0]            q;
    logic                      out_free;
    logic                      out_load;

    oas_ram #(.WIDTH(COEF_W), .DEPTH(FRAME_SIZE)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (head.addr),
        .wdata (head.coef),
        .re    (win_re),
        .raddr (head.addr),
        .rdata (win_rdata)
    );

    oas_ram #(.WIDTH(ACC_W), .DEPTH(FRAME_SIZE)) u_accum (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (head.slot),
        .rdata (acc_rdata)
    );

    assign clear_done = (state_reg != ST_CLEAR);
    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = (state_reg == ST_IDLE) && !queue_empty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        win_we = pop && head.is_load;
        win_re = pop && !head.is_load;
        acc_re = win_re;

        // Clear sweep after reset, otherwise write back the slot (zero once emitted).
        acc_we    = (state_reg == ST_CLEAR) || (state_reg == ST_SCALE);
        acc_waddr = (state_reg == ST_CLEAR) ? clear_cnt_reg : job_reg.slot;
        acc_wdata = ((state_reg == ST_CLEAR) || job_reg.emit) ? '0 : sum_reg;

        // Round Q.35 product to Q.20: add half, floor shift.
        rnd_t    = prod_reg + PROD_W'(RND_BIAS);
        rnd      = $signed(rnd_t[PROD_W-1:RND_SHIFT]);
        sum_wide = $signed({acc_rdata[ACC_W-1], acc_rdata}) + (ACC_W+1)'(rnd);

        mag = sum_reg[ACC_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        q   = mprod_reg[MPROD_W-1:OUT_SHIFT];

        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        job_next        = job_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        mprod_next      = mprod_reg;
        neg_next        = neg_reg;
        out_load        = 1'b0;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == POS_W'(FRAME_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_next = head;
                    if (!head.is_load)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = job_reg.sample * $signed({1'b0, win_rdata});
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
                begin
                    sum_next = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                               : {1'b0, {(ACC_W-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[ACC_W-1:0];
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mprod_next = mag * output_scale;
                neg_next   = sum_reg[ACC_W-1];
                state_next = job_reg.emit ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (neg_reg)
                    begin
                        out_sample_next = (q > Q_W'(OUT_NEG_MAG)) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                                  : OUT_W'(~q + 1'b1);
                    end
                    else
                    begin
                        out_sample_next = (q > Q_W'(OUT_POS_MAX)) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                                  : q[OUT_W-1:0];
                    end
                    out_last_next = job_reg.last;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        prod_reg       <= prod_next;
        sum_reg        <= sum_next;
        mprod_reg      <= mprod_next;
        neg_reg        <= neg_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTHESIS
    a_sample_starts_multiply: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.is_load) |=> (state_reg == ST_MUL))
        else $error("sample request did not enter the multiply step");

    a_out_only_when_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> job_reg.emit)
        else $error("output step reached for a non-emitting sample");

    a_valid_rises_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("output valid raised outside the output step");
`endif

endmodule

>>> rtl/overlap_add_synthesis.sv
// Top level of the weighted overlap-add synthesis stage: configuration
// registers plus the front, request queue and back. Depends on oas_pkg,
// oas_front, oas_queue, oas_back (and through it oas_ram).
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tdata (sample, coef, index), s_tuser
//  m_      | out       | m_tvalid / m_tready | m_tdata (out_sample), m_tlast
//  cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// In the back a window load is written as it is taken; a sample goes through read,
// multiply, accumulate and write back, and an emitting one waits on m_tready to output.
// The front and the 2-entry queue take requests ahead of the back; s_tready
// drops while the queue is full.
// After reset the ring is cleared one slot a cycle, with s_tready low until the sweep
// ends; the output register holds a sample while m_tready is low.
module overlap_add_synthesis
    import oas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,    // sample_value[23:0], coef_value[39:24],
                                               // coef_index[49:40], zero[55:50]
    input  logic [TUSER_IN_W-1:0]  s_tuser,    // command[0], final_frame[1]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // out_sample[15:0]
    output logic                   m_tlast,    // stream_end
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SCALE_W-1:0]     cfg_wdata
);

    logic [HOP_CFG_W-1:0] hop_size_reg, hop_size_next;
    logic [SCALE_W-1:0]   output_scale_reg, output_scale_next;

    logic     clear_done;
    logic     queue_full;
    logic     queue_empty;
    logic     push;
    logic     pop;
    oas_job_t push_job;
    oas_job_t head;

    // Take a register write on any cycle with cfg_we high; write only while no
    // request is in flight.
    always_comb
    begin
        hop_size_next     = hop_size_reg;
        output_scale_next = output_scale_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HOP_SIZE:     hop_size_next     = cfg_wdata[HOP_CFG_W-1:0];
                REG_OUTPUT_SCALE: output_scale_next = cfg_wdata;
                default:          hop_size_next     = hop_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_size_reg     <= HOP_RESET;
            output_scale_reg <= SCALE_RESET;
        end
        else
        begin
            hop_size_reg     <= hop_size_next;
            output_scale_reg <= output_scale_next;
        end
    end

    // Classify requests and track frame position / ring base.
    oas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .hop_size   (hop_size_reg),
        .clear_done (clear_done),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Decouple front from back.
    oas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    // Window table, accumulator ring and output datapath.
    oas_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .output_scale (output_scale_reg),
        .clear_done   (clear_done),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

>>> dv/overlap_add_synthesis_tb.sv
// Self-checking testbench of overlap_add_synthesis: a directed table, then one random
// frame of window loads and samples and a short tail into the next, checked against
// an in-bench overlap-add predictor. Depends on oas_pkg and the block's RTL.
module overlap_add_synthesis_tb;
    import oas_pkg::*;

    // Cycles with no request and no output moving before the run is declared hung.
    // Covers the ring clearing pass after reset, the settle waits and long stalls.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles before a register write: samples that emit nothing can still be
    // in the front, the queue and the back when the last output has arrived.
    localparam int SETTLE_CYCLES  = 32;
    // Samples streamed after the first frame has closed.
    localparam int TAIL_SAMPLES   = 150;
    localparam longint ACC_HI     = 64'sd2147483647;
    localparam longint ACC_LO     = -64'sd2147483648;
    localparam int PLAN_ROWS      = 24;

    typedef struct {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COEF_W-1:0]          coef;
        logic [CIDX_W-1:0]          idx;
        logic                       last_frame;
    } req_t;

    typedef struct packed {
        logic [OUT_W-1:0] pcm;
        logic             stream_end;
    } pcm_word_t;

    typedef enum logic {ROW_REG, ROW_REQ} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [SCALE_W-1:0]         reg_val;
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COEF_W-1:0]          coef;
        logic [CIDX_W-1:0]          idx;
        logic                       last_frame;
        bit                         typed;      // use want_* instead of the predictor
        logic [OUT_W-1:0]           want_pcm;
        logic                       want_end;
    } plan_row_t;

    typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_COMB, RDY_CHOKE} ready_mode_e;

    // Directed table. Rows with typed results start from a cleared ring, so the
    // output follows from saturation, a zero coefficient or a zero factor alone.
    plan_row_t plan [PLAN_ROWS] = '{
        // full-scale factor: extreme samples saturate both ways
        '{ROW_REG, REG_OUTPUT_SCALE, 32'hFFFFFFFF, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd32768, 10'd0,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd32768, 10'd1,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd0, 10'd2,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd32767, 10'd3,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd32768, 10'd1023,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh7FFFFF, 16'd0, 10'd0,
          1'b0, 1'b1, 16'h7FFF, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh800000, 16'd0, 10'd0,
          1'b0, 1'b1, 16'h8000, 1'b0},
        // zero coefficient leaves the slot empty
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh800000, 16'd0, 10'd0,
          1'b0, 1'b1, 16'h0000, 1'b0},
        // zero factor silences a full-scale slot
        '{ROW_REG, REG_OUTPUT_SCALE, 32'd0, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh7FFFFF, 16'd0, 10'd0,
          1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_REG, REG_OUTPUT_SCALE, SCALE_RESET, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        // hop of one: later positions stay in the ring
        '{ROW_REG, REG_HOP_SIZE, 32'd1, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd32767, 10'd4,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh7FFFFF, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0, 1'b0},
        // final flag in mid frame: emitted, no stream end
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd1, 10'd5,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'shFFFFFF, 16'd0, 10'd0,
          1'b1, 1'b0, 16'h0, 1'b0},
        // hop beyond the frame saturates to the frame size
        '{ROW_REG, REG_HOP_SIZE, 32'd2047, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd16384, 10'd6,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh2AAAAA, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0, 1'b0},
        // hop zero selects a quarter frame
        '{ROW_REG, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_LOAD, 24'sd0, 16'd21845, 10'd7,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REQ, REG_HOP_SIZE, 32'd0, CMD_SAMPLE, 24'sh555555, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_REG, REG_HOP_SIZE, 32'd1024, CMD_SAMPLE, 24'sd0, 16'd0, 10'd0,
          1'b0, 1'b0, 16'h0000, 1'b0}
    };

    // Block ports
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SCALE_W-1:0]     cfg_wdata;

    // Predictor state: own copy of the ring, the window and the registers
    logic signed [ACC_W-1:0] ring_acc [FRAME_SIZE];
    logic [COEF_W-1:0]       window [FRAME_SIZE];
    bit                      win_loaded [FRAME_SIZE];
    logic [POS_W-1:0]        base_slot;
    logic [POS_W-1:0]        next_pos;
    logic [HOP_CFG_W-1:0]    hop_reg;
    logic [SCALE_W-1:0]      scale_reg;

    pcm_word_t   pcm_expected [$];
    pcm_word_t   pcm_head;

    // Run statistics
    int          mismatches;
    int          reqs_sent;
    int          loads_sent;
    int          pcm_checked;
    int          frames_done;
    int          stream_ends;
    int          reg_writes;
    int          idle_cycles;
    int          burst_left;
    int          cycle_count;
    int          ready_span;
    ready_mode_e ready_mode = RDY_OPEN;

    overlap_add_synthesis dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Hop in force: zero means a quarter frame, anything past the frame clips to it.
    function automatic int unsigned hop_in_use();
        int unsigned h;
        h = hop_reg;
        if (h == 0)
            h = FRAME_SIZE / 4;
        if (h > FRAME_SIZE)
            h = FRAME_SIZE;
        return h;
    endfunction

    // Apply the Q16.16 factor, drop 36 bits toward zero, clip to int16.
    function automatic logic [OUT_W-1:0] scale_to_pcm(input logic signed [ACC_W-1:0] acc);
        longint unsigned mag;
        longint unsigned q;
        mag = (acc < 0) ? -longint'(acc) : longint'(acc);
        q   = (mag * scale_reg) >> OUT_SHIFT;
        if (acc < 0)
            return (q > OUT_NEG_MAG) ? 16'h8000 : OUT_W'(64'd0 - q);
        return (q > OUT_POS_MAX) ? 16'h7FFF : q[OUT_W-1:0];
    endfunction

    // Advance the predictor by one accepted request; return 1 when it emits a sample.
    function automatic bit overlap_add(input req_t r, output pcm_word_t res);
        int unsigned pos;
        int unsigned slot;
        int unsigned h;
        longint      prod;
        longint      total;
        bit          emit;
        res = '0;
        if (r.cmd == CMD_LOAD)
        begin
            window[r.idx]     = r.coef;
            win_loaded[r.idx] = 1'b1;
            return 1'b0;
        end
        pos  = next_pos;
        slot = (base_slot + pos) % FRAME_SIZE;
        h    = hop_in_use();
        prod = longint'(r.sample) * longint'(window[pos]);
        // round to Q.20: add half an LSB, then floor
        total = longint'(ring_acc[slot]) + ((prod + RND_BIAS) >>> RND_SHIFT);
        if (total > ACC_HI)
            total = ACC_HI;
        else if (total < ACC_LO)
            total = ACC_LO;
        ring_acc[slot] = total[ACC_W-1:0];
        emit = (pos < h) || r.last_frame;
        if (emit)
        begin
            res.pcm        = scale_to_pcm(ring_acc[slot]);
            res.stream_end = r.last_frame && (pos == FRAME_SIZE - 1);
            ring_acc[slot] = '0;
        end
        if (pos == FRAME_SIZE - 1)
        begin
            // frame closes: a final frame rewinds the ring, any other moves it by a hop
            next_pos  = '0;
            base_slot = r.last_frame ? '0 : POS_W'((base_slot + h) % FRAME_SIZE);
            frames_done++;
        end
        else
        begin
            next_pos = POS_W'(pos + 1);
        end
        return emit;
    endfunction

    // Drop valid and hold until every expected sample is out.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pcm_expected.size() != 0);
    endtask

    // Leave the block idle, then let in-flight silent requests finish.
    task automatic quiesce();
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Raise the write strobe with index and value; the caller lowers it after the group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_HOP_SIZE)
            hop_reg = val[HOP_CFG_W-1:0];
        else
            scale_reg = val;
        reg_writes++;
    endtask

    // Present one request in the sender's burst pattern, hold it until taken,
    // then record what it should produce.
    task automatic send_request(input req_t r, input bit typed, input pcm_word_t want);
        int        gap;
        pcm_word_t got;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_IN_W - SAMPLE_W - COEF_W - CIDX_W){1'b0}},
                     r.idx, r.coef, r.sample};
        s_tuser  <= {r.last_frame, r.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        if (overlap_add(r, got))
            pcm_expected.push_back(typed ? want : got);
        reqs_sent++;
        if (r.cmd == CMD_LOAD)
            loads_sent++;
    endtask

    // Receiver: pick a new stall pattern whenever the current span runs out
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (ready_span == 0)
        begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            ready_span <= $urandom_range(64, 512);
        end
        else
        begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            RDY_OPEN:  m_tready <= 1'b1;
            RDY_COIN:  m_tready <= 1'($urandom_range(0, 1));
            RDY_COMB:  m_tready <= (cycle_count % 8) < 5;
            RDY_CHOKE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= 1'b1;
        endcase
    end

    // Scoreboard: each output sample against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pcm_expected.size() == 0)
            begin
                report_mismatch($sformatf("output %0d (end %b) with nothing expected",
                                          $signed(m_tdata), m_tlast));
            end
            else
            begin
                pcm_head = pcm_expected.pop_front();
                pcm_checked++;
                if (m_tdata !== pcm_head.pcm)
                    report_mismatch($sformatf("out_sample %0d, expected %0d",
                                              $signed(m_tdata), $signed(pcm_head.pcm)));
                if (m_tlast !== pcm_head.stream_end)
                    report_mismatch($sformatf("stream_end %b, expected %b",
                                              m_tlast, pcm_head.stream_end));
                if (pcm_head.stream_end)
                    stream_ends++;
            end
        end
    end

    // Watchdog: count cycles in which neither side moves
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d samples outstanding",
                     idle_cycles, pcm_expected.size());
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        req_t      r;
        pcm_word_t want;
        int        pick;
        int        until_reconfig;
        int        tail_count;
        logic [SCALE_W-1:0] hop_val;
        logic [SCALE_W-1:0] scale_val;

        // Hold every input at a known value while reset is low.
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        foreach (ring_acc[k])
        begin
            ring_acc[k]   = '0;
            window[k]     = '0;
            win_loaded[k] = 1'b0;
        end
        base_slot      = '0;
        next_pos       = '0;
        hop_reg        = HOP_RESET;
        scale_reg      = SCALE_RESET;
        burst_left     = 0;
        tail_count     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: register rows wait for an idle block.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                quiesce();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                cfg_we <= 1'b0;
            end
            else
            begin
                r.cmd        = plan[i].cmd;
                r.sample     = plan[i].sample;
                r.coef       = plan[i].coef;
                r.idx        = plan[i].idx;
                r.last_frame = plan[i].last_frame;
                want.pcm        = plan[i].want_pcm;
                want.stream_end = plan[i].want_end;
                send_request(r, plan[i].typed, want);
            end
        end

        // Random traffic: finish the first frame and close it as an ordinary frame,
        // then a tail into the next frame that adds onto the slots still held.
        // Each window entry is loaded just before its first sample reads it.
        until_reconfig = $urandom_range(150, 400);
        while (frames_done < 1 || tail_count < TAIL_SAMPLES)
        begin
            if (until_reconfig == 0)
            begin
                quiesce();
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       hop_val = 0;
                    1:       hop_val = 1;
                    2:       hop_val = FRAME_SIZE;
                    3:       hop_val = 2047;
                    4:       hop_val = 256;
                    5:       hop_val = $urandom_range(FRAME_SIZE + 1, 2046);
                    default: hop_val = $urandom_range(2, FRAME_SIZE - 1);
                endcase
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       scale_val = '0;
                    1:       scale_val = '1;
                    2:       scale_val = SCALE_RESET;
                    3:       scale_val = $urandom;
                    default: scale_val = $urandom >> $urandom_range(8, 22);
                endcase
                write_reg(REG_HOP_SIZE, hop_val);
                write_reg(REG_OUTPUT_SCALE, scale_val);
                cfg_we <= 1'b0;
                until_reconfig = $urandom_range(150, 400);
            end

            // Now and then hold the sender until every expected output is out.
            if ($urandom_range(0, 199) == 0)
                drain_outputs();

            // Random content in every field; the command decides which ones count.
            pick = $urandom_range(0, 7);
            r.coef = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd32767 :
                     (pick == 2) ? 16'd32768 : COEF_W'($urandom_range(0, 32768));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                r.sample = 24'sh7FFFFF;
            else if (pick == 1)
                r.sample = 24'sh800000;
            else if (pick < 4)
                r.sample = SAMPLE_W'($urandom_range(0, 8191)) - 24'sd4096;
            else
                r.sample = SAMPLE_W'($urandom);
            r.idx        = CIDX_W'($urandom);
            r.last_frame = 1'($urandom_range(0, 1));

            if (!win_loaded[next_pos] || $urandom_range(0, 63) == 0)
            begin
                r.cmd = CMD_LOAD;
                if (!win_loaded[next_pos])
                    r.idx = next_pos;
            end
            else
            begin
                r.cmd = CMD_SAMPLE;
                if (frames_done == 0)
                    // ordinary frame: a stray final flag now and then, never at its end
                    r.last_frame = (next_pos != POS_W'(FRAME_SIZE - 1)) &&
                                   ($urandom_range(0, 63) == 0);
                else
                    // tail: final flags mixed in, each emitting its slot
                    r.last_frame = ($urandom_range(0, 3) == 0);
                until_reconfig--;
                if (frames_done >= 1)
                    tail_count++;
            end
            send_request(r, 1'b0, '0);
        end

        // Wind down: everything out, then the settle wait for strays.
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pcm_expected.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", pcm_expected.size()));

        $display("run: %0d requests (%0d window loads), %0d output samples checked",
                 reqs_sent, loads_sent, pcm_checked);
        $display("run: %0d frames closed, %0d stream ends, %0d register writes, %0d mismatches",
                 frames_done, stream_ends, reg_writes, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
